@@ rtl/core/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants of the priority task table
// Beat layouts, command and status codes, and the cell operation codes.
// ----------------------------------------------------------------------------
package ptt_pkg;

  localparam int CAPACITY  = 64;
  localparam int ID_BITS   = 16;
  localparam int PRIO_BITS = 32;

  // Command codes
  localparam logic [1:0] CMD_ADD    = 2'd0;
  localparam logic [1:0] CMD_CHANGE = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_EXEC   = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_EMPTY   = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_PRESENT = 3'd4;

  // Cell operations
  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_CLOSE  = 2'd3;

  typedef struct packed {
    logic [1:0]                  command;
    logic [ID_BITS-1:0]          user_id;
    logic [ID_BITS-1:0]          task_id;
    logic signed [PRIO_BITS-1:0] priority_req;
  } request_t;

  typedef struct packed {
    logic [ID_BITS-1:0] owner;
    logic [2:0]         status;
  } response_t;

  typedef struct packed {
    logic                        valid;
    logic signed [PRIO_BITS-1:0] prio;
    logic [ID_BITS-1:0]          task_id;
    logic [ID_BITS-1:0]          user_id;
  } entry_t;

  typedef struct packed {
    logic signed [PRIO_BITS-1:0] prio;
    logic [ID_BITS-1:0]          task_id;
  } key_t;

  typedef struct packed {
    logic [1:0]         op;
    key_t               key;
    logic [ID_BITS-1:0] id;
    entry_t             ins;
  } cell_ctl_t;

endpackage

@@ rtl/core/ptt_cell.sv @@
// ----------------------------------------------------------------------------
// ptt_cell: one slot of the sorted task chain
// Holds one entry, compares it against the broadcast key and id, and moves
// entries to or from its neighbors on insert, pop and close operations.
// ----------------------------------------------------------------------------
module ptt_cell (
  input  logic              clk,
  input  logic              rst,
  input  ptt_pkg::cell_ctl_t ctl,
  input  logic              left_gt,
  input  ptt_pkg::entry_t   left_ent,
  input  ptt_pkg::entry_t   right_ent,
  output ptt_pkg::entry_t   ent,
  output logic              gt,
  output logic              eq,
  output logic              match
);

  logic            valid;
  ptt_pkg::entry_t data;
  ptt_pkg::entry_t ent_next;
  logic            gt_now;
  logic            eq_now;
  logic            match_now;

  always_comb begin
    ent       = data;
    ent.valid = valid;
  end

  // Key order: priority (signed), then task id (unsigned)
  always_comb begin
    gt_now = !valid ||
             ($signed(ctl.key.prio) > $signed(data.prio)) ||
             (($signed(ctl.key.prio) == $signed(data.prio)) &&
              (ctl.key.task_id > data.task_id));
    eq_now    = valid && (ctl.key.prio == data.prio) && (ctl.key.task_id == data.task_id);
    match_now = valid && (ctl.id == data.task_id);
  end

  always_comb begin
    ent_next = ent;
    unique case (ctl.op)
      ptt_pkg::OP_HOLD: begin
      end
      ptt_pkg::OP_INSERT: begin
        // first lower cell takes the new entry, the rest move right
        if (gt) begin
          ent_next = left_gt ? left_ent : ctl.ins;
        end
      end
      ptt_pkg::OP_POP: begin
        ent_next = right_ent;
      end
      ptt_pkg::OP_CLOSE: begin
        if (gt || eq) begin
          ent_next = right_ent;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ent_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    data  <= ent_next;
    gt    <= gt_now;
    eq    <= eq_now;
    match <= match_now;
  end

endmodule

@@ rtl/core/priority_task_table_core.sv @@
// ----------------------------------------------------------------------------
// priority_task_table_core: updatable max-priority task table
// A chain of cells kept sorted by priority, then task id, highest first.
// ----------------------------------------------------------------------------
// Usage:
//   Drive request with start high; the beat is taken on a clock edge where
//   busy is low. Each command yields exactly one response beat, shown on
//   response for one cycle with done high; the receiver cannot stall it.
//   Valid entries always sit packed at the front of the chain in order, so
//   the top task is in cell 0 and full means the last cell is occupied.
// Steps after the accept edge:
//   add, execute top, and any failing command: compare, then act in DECIDE
//   remove: find, fetch its key, compare again (RSCAN), close the gap (RSHIFT)
//   change: a remove followed by a reinsert with the new priority (SCAN, DECIDE)
//   The response beat appears in the cycle busy drops, so the next command
//   may be taken in the same cycle. Each chain update acts on the registered
//   cell compare flags, in the cycle after the compare that sets them.
// Reset: clears all cell valid bits and the sequencer; the table is empty.
// ----------------------------------------------------------------------------
module priority_task_table_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  ptt_pkg::request_t   request,
  output logic                busy,
  output logic                done,
  output ptt_pkg::response_t  response
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RSCAN  = 3'd2;
  localparam logic [2:0] S_RSHIFT = 3'd3;
  localparam logic [2:0] S_SCAN   = 3'd4;

  logic [2:0]          state;
  logic                reins;
  logic [1:0]          cmd;
  ptt_pkg::entry_t     pend;
  ptt_pkg::key_t       ckey;
  ptt_pkg::cell_ctl_t  ctl;

  ptt_pkg::entry_t     ent   [ptt_pkg::CAPACITY];
  logic [ptt_pkg::CAPACITY-1:0] gt_q;
  logic [ptt_pkg::CAPACITY-1:0] eq_q;
  logic [ptt_pkg::CAPACITY-1:0] match_q;

  logic                              present;
  logic                              full;
  logic                              empty;
  logic signed [ptt_pkg::PRIO_BITS-1:0] hit_prio;
  logic [ptt_pkg::ID_BITS-1:0]       hit_user;
  logic                              accept;

  assign busy    = (state != S_IDLE);
  assign accept  = start && !busy;
  assign present = |match_q;
  assign full    = ent[ptt_pkg::CAPACITY-1].valid;
  assign empty   = !ent[0].valid;

  // Pull the fields of the one matching cell
  always_comb begin
    hit_prio = '0;
    hit_user = '0;
    for (int i = 0; i < ptt_pkg::CAPACITY; i++) begin
      if (match_q[i]) begin
        hit_prio = hit_prio | ent[i].prio;
        hit_user = hit_user | ent[i].user_id;
      end
    end
  end

  // Broadcast to the chain; on the accept cycle compare against the new beat
  always_comb begin
    ctl.op  = ptt_pkg::OP_HOLD;
    ctl.ins = pend;
    if (state == S_IDLE) begin
      ctl.key.prio    = request.priority_req;
      ctl.key.task_id = request.task_id;
      ctl.id          = request.task_id;
    end else begin
      ctl.key = ckey;
      ctl.id  = pend.task_id;
    end
    unique case (state)
      S_DECIDE: begin
        if (reins) begin
          ctl.op = ptt_pkg::OP_INSERT;
        end else if (cmd == ptt_pkg::CMD_ADD && !present && !full) begin
          ctl.op = ptt_pkg::OP_INSERT;
        end else if (cmd == ptt_pkg::CMD_EXEC && !empty) begin
          ctl.op = ptt_pkg::OP_POP;
        end
      end
      S_RSHIFT: ctl.op = ptt_pkg::OP_CLOSE;
      S_IDLE, S_RSCAN, S_SCAN: begin
      end
      default: begin
      end
    endcase
  end

  // The cell chain
  for (genvar i = 0; i < ptt_pkg::CAPACITY; i++) begin : g_cell
    ptt_pkg::entry_t left_ent;
    ptt_pkg::entry_t right_ent;
    logic            left_gt;

    if (i == 0) begin : g_first
      assign left_ent = '0;
      assign left_gt  = 1'b0;
    end else begin : g_mid_l
      assign left_ent = ent[i-1];
      assign left_gt  = gt_q[i-1];
    end

    if (i == ptt_pkg::CAPACITY - 1) begin : g_last
      assign right_ent = '0;
    end else begin : g_mid_r
      assign right_ent = ent[i+1];
    end

    ptt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .left_gt   (left_gt),
      .left_ent  (left_ent),
      .right_ent (right_ent),
      .ent       (ent[i]),
      .gt        (gt_q[i]),
      .eq        (eq_q[i]),
      .match     (match_q[i])
    );
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      reins <= 1'b0;
      done  <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          done <= 1'b0;
          if (start) begin
            state <= S_DECIDE;
            reins <= 1'b0;
          end
        end
        S_DECIDE: begin
          if (!reins && present &&
              (cmd == ptt_pkg::CMD_CHANGE || cmd == ptt_pkg::CMD_REMOVE)) begin
            state <= S_RSCAN;
            done  <= 1'b0;
          end else begin
            state <= S_IDLE;
            done  <= 1'b1;
          end
        end
        S_RSCAN: begin
          state <= S_RSHIFT;
          done  <= 1'b0;
        end
        S_RSHIFT: begin
          if (cmd == ptt_pkg::CMD_REMOVE) begin
            state <= S_IDLE;
            done  <= 1'b1;
          end else begin
            // reinsert the changed task with its new priority
            state <= S_SCAN;
            reins <= 1'b1;
            done  <= 1'b0;
          end
        end
        S_SCAN: begin
          state <= S_DECIDE;
          done  <= 1'b0;
        end
        default: begin
          state <= S_IDLE;
          done  <= 1'b0;
        end
      endcase
    end
  end

  // Beat registers and working key
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd          <= request.command;
      pend.valid   <= 1'b1;
      pend.prio    <= request.priority_req;
      pend.task_id <= request.task_id;
      pend.user_id <= request.user_id;
    end
    if (state == S_DECIDE) begin
      if (reins) begin
        response.owner  <= '0;
        response.status <= ptt_pkg::ST_OK;
      end else begin
        unique case (cmd)
          ptt_pkg::CMD_ADD: begin
            response.owner <= '0;
            if (present) begin
              response.status <= ptt_pkg::ST_PRESENT;
            end else if (full) begin
              response.status <= ptt_pkg::ST_FULL;
            end else begin
              response.status <= ptt_pkg::ST_OK;
            end
          end
          ptt_pkg::CMD_EXEC: begin
            if (empty) begin
              response.owner  <= '0;
              response.status <= ptt_pkg::ST_EMPTY;
            end else begin
              response.owner  <= ent[0].user_id;
              response.status <= ptt_pkg::ST_OK;
            end
          end
          ptt_pkg::CMD_CHANGE, ptt_pkg::CMD_REMOVE: begin
            response.owner <= '0;
            if (!present) begin
              response.status <= ptt_pkg::ST_ABSENT;
            end else begin
              response.status <= ptt_pkg::ST_OK;
              ckey.prio       <= hit_prio;
              ckey.task_id    <= pend.task_id;
              pend.user_id    <= hit_user;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (state == S_RSHIFT) begin
      response.owner  <= '0;
      response.status <= ptt_pkg::ST_OK;
      ckey.prio       <= pend.prio;
      ckey.task_id    <= pend.task_id;
    end
  end

endmodule

@@ rtl/core/ptt_checker.sv @@
// ----------------------------------------------------------------------------
// ptt_checker: port-level checks of the priority task table
// Watches the command and response ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module ptt_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input ptt_pkg::response_t response
);

  // A response beat only shows once the command is finished
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("response beat while busy");

  // An accepted command drives busy high, with done low, before its response beat
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("command finished without a working cycle");

  // Status stays within its defined codes
  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (response.status == ptt_pkg::ST_OK || response.status == ptt_pkg::ST_EMPTY ||
              response.status == ptt_pkg::ST_FULL || response.status == ptt_pkg::ST_ABSENT ||
              response.status == ptt_pkg::ST_PRESENT))
    else $error("undefined status code");

  // Owner is zero on every failing command
  a_owner_zero: assert property (@(posedge clk) disable iff (rst)
    (done && response.status != ptt_pkg::ST_OK) |-> (response.owner == '0))
    else $error("owner set on a failing command");

endmodule

bind priority_task_table_core ptt_checker u_ptt_checker (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .response (response)
);

@@ sim/priority_task_table_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_task_table_core_tb: self-checking bench for the task table core
// Drives add, change, remove and execute-top commands in bursts, keeps its
// own copy of the table to predict every response beat, and checks each
// response in order as it appears with done high.
// ----------------------------------------------------------------------------
module priority_task_table_core_tb;

  localparam int RANDOM_ITEMS = 800;
  localparam int POOL_SIZE    = 80;
  // Longest legal quiet stretch is a hold-off drain plus the longest burst gap
  // plus a change command, far below this.
  localparam int IDLE_LIMIT   = 2000;
  // Settle time after the last response; the slowest command is a change.
  localparam int TAIL_CYCLES  = 12;

  typedef enum int {MIX_FILL, MIX_CHURN, MIX_DRAIN, MIX_NOISE} mix_e;

  typedef struct {
    ptt_pkg::request_t req;
    bit                hold_off;  // wait for every owed response before offering
  } cmd_item_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  ptt_pkg::request_t  request = '0;
  logic               busy;
  logic               done;
  ptt_pkg::response_t response;
  logic               beat_taken;

  cmd_item_t          cmd_backlog[$];
  ptt_pkg::response_t owed_responses[$];

  // Shadow copy of the table, one slot per cell
  logic                                 tbl_valid[ptt_pkg::CAPACITY];
  logic [ptt_pkg::ID_BITS-1:0]          tbl_task[ptt_pkg::CAPACITY];
  logic [ptt_pkg::ID_BITS-1:0]          tbl_user[ptt_pkg::CAPACITY];
  logic signed [ptt_pkg::PRIO_BITS-1:0] tbl_prio[ptt_pkg::CAPACITY];

  int gap_left = 0;
  int burst_left = 1;
  int idle_cycles = 0;
  int error_count = 0;
  int sent_count = 0;
  int checked_count = 0;
  int cmd_seen[4];
  int status_seen[5];

  priority_task_table_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .request  (request),
    .busy     (busy),
    .done     (done),
    .response (response)
  );

  always #5 clk = ~clk;

  assign beat_taken = start && !busy;

  // Apply one command to the shadow table and return the response it owes.
  function automatic ptt_pkg::response_t table_apply(ptt_pkg::request_t rq);
    ptt_pkg::response_t rsp;
    int hit;
    int free_idx;
    int best;
    rsp.owner  = '0;
    rsp.status = ptt_pkg::ST_OK;
    hit = -1;
    free_idx = -1;
    best = -1;
    for (int i = 0; i < ptt_pkg::CAPACITY; i++) begin
      if (hit < 0 && tbl_valid[i] && tbl_task[i] == rq.task_id) hit = i;
      if (free_idx < 0 && !tbl_valid[i]) free_idx = i;
    end
    case (rq.command)
      ptt_pkg::CMD_ADD: begin
        // Duplicate check wins over the full check
        if (hit >= 0) begin
          rsp.status = ptt_pkg::ST_PRESENT;
        end else if (free_idx < 0) begin
          rsp.status = ptt_pkg::ST_FULL;
        end else begin
          tbl_valid[free_idx] = 1'b1;
          tbl_task[free_idx]  = rq.task_id;
          tbl_user[free_idx]  = rq.user_id;
          tbl_prio[free_idx]  = rq.priority_req;
        end
      end
      ptt_pkg::CMD_CHANGE: begin
        if (hit < 0) rsp.status = ptt_pkg::ST_ABSENT;
        else tbl_prio[hit] = rq.priority_req;
      end
      ptt_pkg::CMD_REMOVE: begin
        if (hit < 0) rsp.status = ptt_pkg::ST_ABSENT;
        else tbl_valid[hit] = 1'b0;
      end
      default: begin
        // Highest priority first, larger task id on a tie
        for (int i = 0; i < ptt_pkg::CAPACITY; i++) begin
          if (tbl_valid[i]) begin
            if (best < 0 || tbl_prio[i] > tbl_prio[best] ||
                (tbl_prio[i] == tbl_prio[best] && tbl_task[i] > tbl_task[best]))
              best = i;
          end
        end
        if (best < 0) begin
          rsp.status = ptt_pkg::ST_EMPTY;
        end else begin
          rsp.owner = tbl_user[best];
          tbl_valid[best] = 1'b0;
        end
      end
    endcase
    return rsp;
  endfunction

  task automatic push_cmd(input logic [1:0] cmd, input logic [ptt_pkg::ID_BITS-1:0] usr,
                          input logic [ptt_pkg::ID_BITS-1:0] tid,
                          input logic [ptt_pkg::PRIO_BITS-1:0] pr, input bit hold);
    cmd_item_t it;
    it.req.command      = cmd;
    it.req.user_id      = usr;
    it.req.task_id      = tid;
    it.req.priority_req = pr;
    it.hold_off         = hold;
    cmd_backlog.push_back(it);
  endtask

  // Driver: offer one command beat at a time, hold it until busy is low,
  // and work in bursts separated by random gaps.
  always @(posedge clk) begin
    cmd_item_t nxt;
    if (rst) begin
      start      <= 1'b0;
      request    <= '0;
      gap_left   <= 0;
      burst_left <= 1;
      for (int i = 0; i < ptt_pkg::CAPACITY; i++) tbl_valid[i] = 1'b0;
    end else begin
      if (beat_taken) begin
        owed_responses.push_back(table_apply(request));
        cmd_seen[request.command]++;
        sent_count++;
      end
      // A beat still waiting on busy stays put; otherwise pick what comes next
      if (!start || beat_taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start    <= 1'b0;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].hold_off &&
                       (beat_taken || busy || owed_responses.size() != 0))) begin
          nxt = cmd_backlog.pop_front();
          start   <= 1'b1;
          request <= nxt.req;
          if (burst_left <= 1) begin
            // Close the burst: often no gap, as often a short one, sometimes a long one
            case ($urandom_range(0, 9))
              0, 1, 2, 3: gap_left <= 0;
              4, 5, 6, 7: gap_left <= $urandom_range(1, 3);
              default:    gap_left <= $urandom_range(4, 12);
            endcase
            burst_left <= $urandom_range(1, 24);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done cycle carries one response beat; match it against
  // the oldest owed response.
  always @(posedge clk) begin
    ptt_pkg::response_t want;
    if (!rst && done) begin
      if (owed_responses.size() == 0) begin
        $display("%0t: response beat with nothing owed, got owner %h status %0d",
                 $time, response.owner, response.status);
        error_count++;
      end else begin
        want = owed_responses.pop_front();
        checked_count++;
        if (response.status < 5) status_seen[response.status]++;
        if (response.owner !== want.owner) begin
          $display("%0t: owner wrong, expected %h, got %h",
                   $time, want.owner, response.owner);
          error_count++;
        end
        if (response.status !== want.status) begin
          $display("%0t: status wrong, expected %0d, got %0d",
                   $time, want.status, response.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog: drop the run if neither a command nor a response moves for
  // too long.
  always @(posedge clk) begin
    if (beat_taken || done) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("priority_task_table_core: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [ptt_pkg::ID_BITS-1:0]   id_pool[POOL_SIZE];
    logic [ptt_pkg::ID_BITS-1:0]   tid;
    logic [ptt_pkg::PRIO_BITS-1:0] pr;
    logic [1:0]                    cmd;
    mix_e                          mix;
    int                            made;
    int                            run_len;
    int                            add_pct;
    int                            chg_pct;
    int                            rem_pct;
    int                            r;
    bit                            hold;

    for (int i = 0; i < 4; i++) cmd_seen[i] = 0;
    for (int i = 0; i < 5; i++) status_seen[i] = 0;

    // Directed opening: empty table, absent ids, extreme fields, duplicate
    // add, priority ties in both directions, and changes that move the top.
    push_cmd(ptt_pkg::CMD_EXEC,   16'h3c3c, 16'hc3c3, 32'h5555_aaaa, 1'b0);
    push_cmd(ptt_pkg::CMD_CHANGE, 16'hffff, 16'h0005, 32'h0000_0001, 1'b0);
    push_cmd(ptt_pkg::CMD_REMOVE, 16'h0000, 16'h0005, 32'h0000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'hffff, 16'h0000, 32'h7fff_ffff, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'h0000, 16'hffff, 32'h8000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'h1234, 16'h0000, 32'h0000_0003, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'ha5a5, 16'h1234, 32'h0000_0007, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'h5a5a, 16'h4321, 32'h0000_0007, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'h0001, 16'h0100, 32'h0000_0007, 1'b0);
    push_cmd(ptt_pkg::CMD_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_EXEC,   16'hffff, 16'hffff, 32'hffff_ffff, 1'b0);
    push_cmd(ptt_pkg::CMD_CHANGE, 16'hbeef, 16'h1234, 32'hffff_ffff, 1'b0);
    push_cmd(ptt_pkg::CMD_CHANGE, 16'h0000, 16'hffff, 32'h7fff_ffff, 1'b0);
    push_cmd(ptt_pkg::CMD_EXEC,   16'h1111, 16'h2222, 32'h3333_3333, 1'b0);
    push_cmd(ptt_pkg::CMD_REMOVE, 16'hffff, 16'h0100, 32'h7fff_ffff, 1'b0);
    push_cmd(ptt_pkg::CMD_REMOVE, 16'h0000, 16'h0100, 32'h8000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_CHANGE, 16'h0000, 16'h1234, 32'h8000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_ADD,    16'hffff, 16'h8000, 32'h8000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0);
    push_cmd(ptt_pkg::CMD_EXEC,   16'h0000, 16'h0000, 32'h0000_0000, 1'b0);

    // Random part: ids mostly from a fixed pool so that adds collide and
    // changes and removes hit, priorities bunched so that ties are common.
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hffff;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);

    made = 0;
    mix = MIX_FILL;
    run_len = 140;
    hold = 1'b1;  // drain everything before the random part starts
    while (made < RANDOM_ITEMS) begin
      case (mix)
        MIX_FILL:  begin add_pct = 80; chg_pct = 88; rem_pct = 94; end
        MIX_CHURN: begin add_pct = 35; chg_pct = 60; rem_pct = 80; end
        MIX_DRAIN: begin add_pct = 10; chg_pct = 20; rem_pct = 30; end
        default:   begin add_pct = 25; chg_pct = 50; rem_pct = 75; end
      endcase
      for (int k = 0; k < run_len && made < RANDOM_ITEMS; k++) begin
        r = $urandom_range(0, 99);
        if (r < add_pct) cmd = ptt_pkg::CMD_ADD;
        else if (r < chg_pct) cmd = ptt_pkg::CMD_CHANGE;
        else if (r < rem_pct) cmd = ptt_pkg::CMD_REMOVE;
        else cmd = ptt_pkg::CMD_EXEC;
        if (mix != MIX_NOISE && $urandom_range(0, 9) < 7)
          tid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
          tid = 16'($urandom);
        case ($urandom_range(0, 7))
          0, 1, 2: pr = 32'($urandom_range(0, 8)) - 32'd4;
          3:       pr = 32'h7fff_ffff;
          4:       pr = 32'h8000_0000;
          default: pr = 32'($urandom);
        endcase
        push_cmd(cmd, 16'($urandom), tid, pr, hold);
        hold = 1'b0;
        made++;
      end
      case ($urandom_range(0, 3))
        0:       mix = MIX_FILL;
        1:       mix = MIX_CHURN;
        2:       mix = MIX_DRAIN;
        default: mix = MIX_NOISE;
      endcase
      run_len = (mix == MIX_FILL) ? $urandom_range(60, 130) : $urandom_range(20, 80);
      hold = ($urandom_range(0, 3) == 0);
    end

    // Hold reset, then release it on a clock edge
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for the backlog to go out, then for every owed response
    while (cmd_backlog.size() != 0 || start) @(posedge clk);
    while (owed_responses.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d command beats: add %0d, change %0d, remove %0d, execute %0d",
             sent_count, cmd_seen[ptt_pkg::CMD_ADD], cmd_seen[ptt_pkg::CMD_CHANGE],
             cmd_seen[ptt_pkg::CMD_REMOVE], cmd_seen[ptt_pkg::CMD_EXEC]);
    $display("%0d responses checked: ok %0d, empty %0d, full %0d, absent %0d, present %0d",
             checked_count, status_seen[ptt_pkg::ST_OK], status_seen[ptt_pkg::ST_EMPTY],
             status_seen[ptt_pkg::ST_FULL], status_seen[ptt_pkg::ST_ABSENT],
             status_seen[ptt_pkg::ST_PRESENT]);
    if (error_count == 0) begin
      $display("priority_task_table_core: match");
    end else begin
      $display("priority_task_table_core: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/ptt_pkg.sv
rtl/core/ptt_cell.sv
rtl/core/priority_task_table_core.sv
rtl/core/ptt_checker.sv
sim/priority_task_table_core_tb.sv
